@@ src/tdfm_pkg.sv @@
// Package with shared constants, types and helper functions for the tile matcher.
package tdfm_pkg;

    localparam int MAX_TILES = 1024;
    localparam int TILE_ROWS = 8;
    localparam int WORD_W = 64;
    localparam int ROW_W = 3;
    localparam int TILE_W = 10;
    localparam int CNT_W = 11;
    localparam int ADDR_W = 13;
    localparam int MEM_DEPTH = MAX_TILES * TILE_ROWS;
    localparam logic [2:0] PAIRS_RESET = 3'd4;
    localparam logic [1:0] REG_PLANE_PAIRS = 2'd0;

    typedef struct packed {
        logic       load_row;
        logic       clear_search;
        logic       issue_read;
        logic       next_flip;
        logic       next_tile;
        logic       store_row;
        logic       commit_new;
    } dp_cmd_t;

    typedef struct packed {
        logic       row_last;
        logic       tile_left;
        logic       store_full;
        logic       rows_done;
        logic       match_ok;
        logic       last_flip;
    } dp_status_t;

    function automatic logic [WORD_W-1:0] reverse_each_byte(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int b = 0; b < 8; b++) begin
            for (int k = 0; k < 8; k++) begin
                r[8*b + 7 - k] = v[8*b + k];
            end
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] pair_mask(input logic [2:0] pairs);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int p = 0; p < 4; p++) begin
            if (p == 0 || 3'(p) < pairs) begin
                m[16*p +: 16] = 16'hffff;
            end
        end
        return m;
    endfunction

endpackage

@@ src/tdfm_ram.sv @@
// Generic single-port RAM with registered read data.
module tdfm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ src/tdfm_datapath.sv @@
// Datapath: row conversion, row buffer, tile store and match comparison.
module tdfm_datapath
    import tdfm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    input  logic [2:0]          plane_pairs,
    input  logic [7:0]          pixel_0,
    input  logic [7:0]          pixel_1,
    input  logic [7:0]          pixel_2,
    input  logic [7:0]          pixel_3,
    input  logic [7:0]          pixel_4,
    input  logic [7:0]          pixel_5,
    input  logic [7:0]          pixel_6,
    input  logic [7:0]          pixel_7,
    output logic [TILE_W-1:0]   tile_index,
    output logic                vflip,
    output logic                hflip
);

    logic [WORD_W-1:0] row_buf_reg [TILE_ROWS];
    logic [ROW_W-1:0]  row_count_reg;
    logic [CNT_W-1:0]  tiles_stored_reg;
    logic [CNT_W-1:0]  tile_reg;
    logic [1:0]        flip_reg;
    logic [ROW_W-1:0]  ry_reg;
    logic [ROW_W-1:0]  cy_reg;
    logic              cmp_valid_reg;
    logic              mismatch_reg;
    logic [WORD_W-1:0] mask_reg;
    logic [WORD_W-1:0] conv_row;
    logic [WORD_W-1:0] rdata;
    logic [WORD_W-1:0] cmp_word;
    logic [ROW_W-1:0]  sy;
    logic [ADDR_W-1:0] addr;
    logic              we;
    logic [7:0]        px [8];

    assign px[0] = pixel_0;
    assign px[1] = pixel_1;
    assign px[2] = pixel_2;
    assign px[3] = pixel_3;
    assign px[4] = pixel_4;
    assign px[5] = pixel_5;
    assign px[6] = pixel_6;
    assign px[7] = pixel_7;

    always_comb
    begin
        conv_row = '0;
        for (int p = 0; p < 4; p++) begin
            for (int x = 0; x < 8; x++) begin
                conv_row[16*p + 7 - x]     = px[x][2*p];
                conv_row[16*p + 8 + 7 - x] = px[x][2*p + 1];
            end
        end
    end

    assign sy = flip_reg[0] ? (ROW_W'(TILE_ROWS - 1) - ry_reg) : ry_reg;
    assign we = cmd.store_row;
    assign addr = we ? {tiles_stored_reg[TILE_W-1:0], ry_reg} : {tile_reg[TILE_W-1:0], sy};

    tdfm_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MEM_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (we),
        .addr (addr),
        .wdata(row_buf_reg[ry_reg] & mask_reg),
        .rdata(rdata)
    );

    assign cmp_word = flip_reg[1] ? reverse_each_byte(rdata) : rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= '0;
            tiles_stored_reg <= '0;
            tile_reg         <= '0;
            flip_reg         <= '0;
            ry_reg           <= '0;
            cy_reg           <= '0;
            cmp_valid_reg    <= 1'b0;
            mismatch_reg     <= 1'b0;
            mask_reg         <= '1;
        end
        else
        begin
            cmp_valid_reg <= cmd.issue_read;
            cy_reg        <= ry_reg;
            if (cmd.load_row)
            begin
                row_count_reg <= row_count_reg + 1'b1;
                mask_reg      <= pair_mask(plane_pairs);
            end
            if (cmd.clear_search)
            begin
                tile_reg     <= '0;
                flip_reg     <= '0;
                ry_reg       <= '0;
                mismatch_reg <= 1'b0;
            end
            if (cmd.issue_read || cmd.store_row)
            begin
                ry_reg <= ry_reg + 1'b1;
            end
            if (cmp_valid_reg && (((cmp_word ^ row_buf_reg[cy_reg]) & mask_reg) != '0))
            begin
                mismatch_reg <= 1'b1;
            end
            if (cmd.next_flip)
            begin
                flip_reg     <= flip_reg + 1'b1;
                ry_reg       <= '0;
                mismatch_reg <= 1'b0;
                if (cmd.next_tile)
                begin
                    tile_reg <= tile_reg + 1'b1;
                end
            end
            if (cmd.commit_new)
            begin
                tiles_stored_reg <= tiles_stored_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_row)
        begin
            row_buf_reg[row_count_reg] <= conv_row;
        end
    end

    assign status.row_last   = (row_count_reg == ROW_W'(TILE_ROWS - 1));
    assign status.tile_left  = (tile_reg < tiles_stored_reg);
    assign status.store_full = (tiles_stored_reg >= CNT_W'(MAX_TILES));
    assign status.rows_done  = (ry_reg == ROW_W'(TILE_ROWS - 1));
    assign status.match_ok   = !mismatch_reg;
    assign status.last_flip  = (flip_reg == 2'd3);

    assign tile_index = tile_reg[TILE_W-1:0];
    assign vflip      = flip_reg[0];
    assign hflip      = flip_reg[1];

endmodule

@@ src/tdfm_ctrl.sv @@
// Controller state machine sequencing row capture, search and tile storing.
module tdfm_ctrl
    import tdfm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  dp_status_t  status,
    output dp_cmd_t     cmd,
    output logic        done,
    output logic        res_match,
    output logic        res_new,
    output logic        res_full
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_EVAL  = 3'd4;
    localparam logic [2:0] ST_STORE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        done       = 1'b0;
        res_match  = 1'b0;
        res_new    = 1'b0;
        res_full   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_row = 1'b1;
                    if (status.row_last)
                    begin
                        cmd.clear_search = 1'b1;
                        state_next       = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (status.tile_left)
                begin
                    state_next = ST_READ;
                end
                else if (status.store_full)
                begin
                    done       = 1'b1;
                    res_full   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.clear_search = 1'b1;
                    state_next       = ST_STORE;
                end
            end
            ST_READ:
            begin
                cmd.issue_read = 1'b1;
                if (status.rows_done)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (status.match_ok)
                begin
                    done       = 1'b1;
                    res_match  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.next_flip = 1'b1;
                    cmd.next_tile = status.last_flip;
                    state_next    = ST_CHECK;
                end
            end
            ST_STORE:
            begin
                cmd.store_row = 1'b1;
                if (status.rows_done)
                begin
                    cmd.commit_new = 1'b1;
                    done           = 1'b1;
                    res_new        = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ src/tile_dedup_flip_matcher.sv @@
// Top level of the tile deduplication matcher with flip search.
//
// A word is one tile row of eight pixels, taken when start is high and busy is low.
// Rows one to seven are taken back to back. After the eighth row the block searches the
// stored tiles through one single-port memory of 8192 rows: each flip trial of a tile
// runs a check, reads the eight rows, waits out the read latency and then evaluates,
// so a full search tries up to four flips per stored tile, and storing a new tile
// writes its eight rows. The result word appears on valid for one cycle and cannot be stalled.
module tile_dedup_flip_matcher
    import tdfm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [7:0]   pixel_0,
    input  logic [7:0]   pixel_1,
    input  logic [7:0]   pixel_2,
    input  logic [7:0]   pixel_3,
    input  logic [7:0]   pixel_4,
    input  logic [7:0]   pixel_5,
    input  logic [7:0]   pixel_6,
    input  logic [7:0]   pixel_7,
    output logic         valid,
    output logic [9:0]   tile_index,
    output logic         vflip,
    output logic         hflip,
    output logic         is_new,
    output logic         store_full,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [2:0]        plane_pairs_reg;
    dp_cmd_t           cmd;
    dp_status_t        status;
    logic              done;
    logic              res_match;
    logic              res_new;
    logic              res_full;
    logic [TILE_W-1:0] dp_index;
    logic              dp_vflip;
    logic              dp_hflip;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_pairs_reg <= PAIRS_RESET;
        end
        else if (psel && penable && pwrite && paddr == REG_PLANE_PAIRS)
        begin
            plane_pairs_reg <= pwdata[2:0];
        end
    end

    assign prdata = (paddr == REG_PLANE_PAIRS) ? {29'd0, plane_pairs_reg} : 32'd0;

    tdfm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .status   (status),
        .cmd      (cmd),
        .done     (done),
        .res_match(res_match),
        .res_new  (res_new),
        .res_full (res_full)
    );

    tdfm_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .plane_pairs(plane_pairs_reg),
        .pixel_0    (pixel_0),
        .pixel_1    (pixel_1),
        .pixel_2    (pixel_2),
        .pixel_3    (pixel_3),
        .pixel_4    (pixel_4),
        .pixel_5    (pixel_5),
        .pixel_6    (pixel_6),
        .pixel_7    (pixel_7),
        .tile_index (dp_index),
        .vflip      (dp_vflip),
        .hflip      (dp_hflip)
    );

    // This counter follows the number of stored tiles and gives the index of a new tile.
    logic [TILE_W-1:0] new_index_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            new_index_reg <= '0;
        end
        else if (cmd.commit_new)
        begin
            new_index_reg <= new_index_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid      <= 1'b0;
            tile_index <= '0;
            vflip      <= 1'b0;
            hflip      <= 1'b0;
            is_new     <= 1'b0;
            store_full <= 1'b0;
        end
        else
        begin
            valid      <= done;
            tile_index <= res_match ? dp_index : (res_new ? new_index_reg : '0);
            vflip      <= res_match & dp_vflip;
            hflip      <= res_match & dp_hflip;
            is_new     <= res_new;
            store_full <= res_full;
        end
    end

endmodule

@@ tb/tile_dedup_flip_matcher_tb.sv @@
// Testbench for the tile matcher: queued row driver, result monitor and a tile-store predictor.
module tile_dedup_flip_matcher_tb
    import tdfm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0][7:0] row_t;
    typedef row_t [7:0] tile_t;

    typedef struct packed {
        logic [9:0] idx;
        logic       vf;
        logic       hf;
        logic       nw;
        logic       full;
    } match_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    row_t        row_in = '0;
    logic        valid;
    logic [9:0]  tile_index;
    logic        vflip;
    logic        hflip;
    logic        is_new;
    logic        store_full;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    row_t        row_fifo[$];
    match_t      match_fifo[$];
    tile_t       tile_history[$];

    logic [63:0] plane_store[MEM_DEPTH];
    logic [63:0] row_words[TILE_ROWS];
    int          rows_in_tile = 0;
    int          tiles_kept = 0;
    logic [2:0]  pairs_cfg = PAIRS_RESET;

    logic        took = 1'b0;
    int          gap_left = 0;
    logic        steady = 1'b0;
    int          mismatches = 0;
    int          idle_cycles = 0;

    always #5 clk = ~clk;

    tile_dedup_flip_matcher u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pixel_0(row_in[0]), .pixel_1(row_in[1]), .pixel_2(row_in[2]), .pixel_3(row_in[3]),
        .pixel_4(row_in[4]), .pixel_5(row_in[5]), .pixel_6(row_in[6]), .pixel_7(row_in[7]),
        .valid(valid), .tile_index(tile_index), .vflip(vflip), .hflip(hflip),
        .is_new(is_new), .store_full(store_full),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    function automatic int used_pairs(input logic [2:0] cfg);
        if (cfg == 0)
            return 1;
        if (cfg > 4)
            return 4;
        return int'(cfg);
    endfunction

    function automatic logic [63:0] planes_of(input row_t px);
        logic [63:0] w;
        w = '0;
        for (int p = 0; p < 4; p++) begin
            for (int x = 0; x < 8; x++) begin
                w[16*p + 7 - x] = px[x][2*p];
                w[16*p + 15 - x] = px[x][2*p + 1];
            end
        end
        return w;
    endfunction

    function automatic logic [63:0] mirror_bytes(input logic [63:0] v);
        logic [63:0] r;
        for (int b = 0; b < 8; b++) begin
            for (int k = 0; k < 8; k++) begin
                r[8*b + 7 - k] = v[8*b + k];
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] plane_mask(input logic [2:0] cfg);
        logic [63:0] m;
        m = '0;
        for (int p = 0; p < used_pairs(cfg); p++) begin
            m[16*p +: 16] = 16'hffff;
        end
        return m;
    endfunction

    function automatic logic fits(input int t, input logic vf, input logic hf,
                                  input logic [63:0] m);
        logic [63:0] s;
        for (int y = 0; y < TILE_ROWS; y++) begin
            s = plane_store[t*TILE_ROWS + (vf ? TILE_ROWS - 1 - y : y)];
            if (hf)
                s = mirror_bytes(s);
            if (((s ^ row_words[y]) & m) != 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic match_row(input row_t px);
        logic [63:0] m;
        match_t res;
        logic found;
        found = 1'b0;
        res = '0;
        row_words[rows_in_tile] = planes_of(px);
        rows_in_tile = (rows_in_tile + 1) % TILE_ROWS;
        if (rows_in_tile == 0) begin
            m = plane_mask(pairs_cfg);
            for (int t = 0; t < tiles_kept && !found; t++) begin
                for (int f = 0; f < 4 && !found; f++) begin
                    if (fits(t, f[0], f[1], m)) begin
                        found = 1'b1;
                        res.idx = t[9:0];
                        res.vf = f[0];
                        res.hf = f[1];
                    end
                end
            end
            if (!found) begin
                if (tiles_kept >= MAX_TILES) begin
                    res.full = 1'b1;
                end else begin
                    for (int y = 0; y < TILE_ROWS; y++)
                        plane_store[tiles_kept*TILE_ROWS + y] = row_words[y] & m;
                    res.idx = tiles_kept[9:0];
                    res.nw = 1'b1;
                    tiles_kept++;
                end
            end
            match_fifo.push_back(res);
        end
    endtask

    always @(posedge clk) begin
        match_t got;
        match_t want;
        took <= start && !busy;
        if (start && !busy)
            match_row(row_in);
        if (valid) begin
            got = '{tile_index, vflip, hflip, is_new, store_full};
            if (match_fifo.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %p", got);
            end else begin
                want = match_fifo.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
        if ((start && !busy) || valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 40000) begin
            $display("[tile_dedup_flip_matcher] ERROR");
            $finish;
        end
    end

    always @(negedge clk) begin
        logic nxt_start;
        row_t nxt_row;
        int r;
        nxt_start = start;
        nxt_row = row_in;
        if (!start || took) begin
            nxt_start = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (row_fifo.size() > 0 && rst_n) begin
                nxt_row = row_fifo.pop_front();
                nxt_start = 1'b1;
                r = $urandom_range(0, 99);
                if (steady || r < 60)
                    gap_left = 0;
                else if (r < 92)
                    gap_left = $urandom_range(1, 3);
                else
                    gap_left = $urandom_range(10, 60);
            end
        end
        start <= nxt_start;
        row_in <= nxt_row;
    end

    task automatic write_pairs(input logic [2:0] v);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = REG_PLANE_PAIRS;
        pwdata = {29'd0, v};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        pairs_cfg = v;
    endtask

    task automatic settle();
        while (row_fifo.size() != 0 || start || match_fifo.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic queue_tile(input tile_t t);
        for (int y = 0; y < TILE_ROWS; y++)
            row_fifo.push_back(t[y]);
        tile_history.push_back(t);
    endtask

    task automatic random_tile(output tile_t t);
        for (int y = 0; y < 8; y++)
            for (int x = 0; x < 8; x++)
                t[y][x] = $urandom_range(0, 255);
    endtask

    task automatic variant_tile(output tile_t t);
        tile_t s;
        logic [7:0] keep;
        s = tile_history[$urandom_range(0, tile_history.size() - 1)];
        keep = 8'((16'd1 << (2 * used_pairs(pairs_cfg))) - 1);
        for (int y = 0; y < 8; y++) begin
            for (int x = 0; x < 8; x++) begin
                t[y][x] = s[y][x];
            end
        end
        if ($urandom_range(0, 1))
            for (int y = 0; y < 8; y++)
                t[y] = s[7 - y];
        if ($urandom_range(0, 1)) begin
            s = t;
            for (int y = 0; y < 8; y++)
                for (int x = 0; x < 8; x++)
                    t[y][x] = s[y][7 - x];
        end
        if ($urandom_range(0, 1))
            for (int y = 0; y < 8; y++)
                for (int x = 0; x < 8; x++)
                    t[y][x] = (t[y][x] & keep) | (8'($urandom_range(0, 255)) & ~keep);
        if ($urandom_range(0, 7) == 0)
            t[$urandom_range(0, 7)][$urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
    endtask

    initial begin
        logic [2:0] phase_pairs[7] = '{3'd4, 3'd1, 3'd0, 3'd2, 3'd7, 3'd3, 3'd4};
        tile_t t;
        tile_t m;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        t = '0;
        queue_tile(t);
        t = {64{8'hff}};
        queue_tile(t);
        for (int y = 0; y < 8; y++)
            for (int x = 0; x < 8; x++)
                t[y][x] = 8'(y * 37 + x * 11 + 1);
        queue_tile(t);
        for (int y = 0; y < 8; y++)
            m[y] = t[7 - y];
        queue_tile(m);
        settle();

        for (int ph = 0; ph < 7; ph++) begin
            if (ph > 0)
                write_pairs(phase_pairs[ph]);
            steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 10; n++) begin
                if ($urandom_range(0, 1) && tile_history.size() > 0)
                    variant_tile(t);
                else
                    random_tile(t);
                queue_tile(t);
            end
            settle();
        end
        repeat (20) @(posedge clk);
        if (mismatches == 0 && match_fifo.size() == 0)
            $display("[tile_dedup_flip_matcher] OK");
        else
            $display("[tile_dedup_flip_matcher] ERROR");
        $finish;
    end
endmodule
